@@ rtl/udss_pkg.sv @@
// ----------------------------------------------------------------------------
// udss_pkg
// Types and constants shared by the counter and display scan blocks, and the
// segment decoder used by the scan.
// ----------------------------------------------------------------------------
package udss_pkg;

  localparam int unsigned COUNT_W  = 14;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned SEG_W    = 7;
  localparam int unsigned ANODE_W  = 4;
  localparam int unsigned BCD_DIGITS = 4;

  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [SEG_W-1:0]    seg_t;
  typedef logic [ANODE_W-1:0]  anode_t;
  typedef logic [3:0]          digit_t;
  typedef digit_t [BCD_DIGITS-1:0] bcd_t;

  localparam count_t  COUNT_TOP        = 14'd9999;
  localparam period_t COUNT_PERIOD_RST = 16'd100;
  localparam period_t SCAN_PERIOD_RST  = 16'd200;
  localparam digit_t  DIGIT_MAX        = 4'd9;

  typedef enum logic [0:0] {
    CFG_COUNT_PERIOD = 1'b0,
    CFG_SCAN_PERIOD  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    count_t count;
    bcd_t   bcd;
  } cnt_state_t;

  function automatic seg_t seg_decode(digit_t digit);
    seg_t seg;
    unique case (digit)
      4'd0: seg = 7'h3F;
      4'd1: seg = 7'h06;
      4'd2: seg = 7'h5B;
      4'd3: seg = 7'h4F;
      4'd4: seg = 7'h66;
      4'd5: seg = 7'h6D;
      4'd6: seg = 7'h7D;
      4'd7: seg = 7'h07;
      4'd8: seg = 7'h7F;
      4'd9: seg = 7'h6F;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/udss_if.sv @@
// ----------------------------------------------------------------------------
// udss_tick_if / udss_disp_if
// Valid/ready channels for the tick input and the display result.
// ----------------------------------------------------------------------------
interface udss_tick_if;
  logic valid;
  logic ready;
  logic direction_up;

  modport source (output valid, output direction_up, input ready);
  modport sink   (input valid, input direction_up, output ready);
endinterface

interface udss_disp_if;
  logic                 valid;
  logic                 ready;
  udss_pkg::anode_t     anode_select;
  udss_pkg::seg_t       segments;
  udss_pkg::count_t     count_value;

  modport source (output valid, output anode_select, output segments,
                  output count_value, input ready);
  modport sink   (input valid, input anode_select, input segments,
                  input count_value, output ready);
endinterface

@@ rtl/udss_phase.sv @@
// ----------------------------------------------------------------------------
// udss_phase
// Tick phase that advances on each advance_i, fires on phase zero and wraps at the period.
// ----------------------------------------------------------------------------
module udss_phase (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  udss_pkg::period_t period_i,
  output logic              fire_o
);

  udss_pkg::period_t phase_q, phase_d;
  logic [udss_pkg::PERIOD_W:0] phase_inc;

  assign fire_o    = (phase_q == '0);
  assign phase_inc = {1'b0, phase_q} + 17'd1;

  always_comb begin
    phase_d = phase_q;
    if (advance_i) begin
      if (phase_inc >= {1'b0, period_i}) begin
        phase_d = '0;
      end else begin
        phase_d = phase_inc[udss_pkg::PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/udss_counter.sv @@
// ----------------------------------------------------------------------------
// udss_counter
// Decimal up/down counter held both in binary and in BCD digits.
// ----------------------------------------------------------------------------
module udss_counter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 up_i,
  output udss_pkg::count_t     count_o,
  output udss_pkg::cnt_state_t next_o
);

  udss_pkg::cnt_state_t state_q, state_d;
  udss_pkg::bcd_t       bcd_inc, bcd_dec;
  logic                 carry;
  logic                 borrow;

  always_comb begin
    carry  = 1'b1;
    borrow = 1'b1;
    for (int i = 0; i < udss_pkg::BCD_DIGITS; i++) begin
      if (carry && state_q.bcd[i] == udss_pkg::DIGIT_MAX) begin
        bcd_inc[i] = '0;
      end else begin
        bcd_inc[i] = state_q.bcd[i] + {3'd0, carry};
        carry      = 1'b0;
      end
      if (borrow && state_q.bcd[i] == '0) begin
        bcd_dec[i] = udss_pkg::DIGIT_MAX;
      end else begin
        bcd_dec[i] = state_q.bcd[i] - {3'd0, borrow};
        borrow     = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    if (step_i) begin
      if (up_i) begin
        if (state_q.count >= udss_pkg::COUNT_TOP) begin
          state_d.count = '0;
          state_d.bcd   = '0;
        end else begin
          state_d.count = state_q.count + 14'd1;
          state_d.bcd   = bcd_inc;
        end
      end else begin
        if (state_q.count == '0 || state_q.count > udss_pkg::COUNT_TOP) begin
          state_d.count = udss_pkg::COUNT_TOP;
          state_d.bcd   = {udss_pkg::DIGIT_MAX, udss_pkg::DIGIT_MAX,
                           udss_pkg::DIGIT_MAX, udss_pkg::DIGIT_MAX};
        end else begin
          state_d.count = state_q.count - 14'd1;
          state_d.bcd   = bcd_dec;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign count_o = state_q.count;
  assign next_o  = state_d;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count <= udss_pkg::COUNT_TOP)
    else $error("counter left its decimal range");

  a_bcd_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count == ({10'd0, state_q.bcd[3]} * 14'd1000 + {10'd0, state_q.bcd[2]} * 14'd100
                    + {10'd0, state_q.bcd[1]} * 14'd10 + {10'd0, state_q.bcd[0]}))
    else $error("BCD digits disagree with the binary count");

  a_wrap_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && up_i && state_q.count == udss_pkg::COUNT_TOP |=> state_q.count == '0)
    else $error("counter did not wrap from the top to zero");
`endif

endmodule

@@ rtl/udss_scan.sv @@
// ----------------------------------------------------------------------------
// udss_scan
// Digit scan: steps the display position and latches anode and segments.
// ----------------------------------------------------------------------------
module udss_scan #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  udss_pkg::bcd_t   digits_i,
  output udss_pkg::anode_t anode_o,
  output udss_pkg::seg_t   seg_o
);

  localparam int unsigned PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [2:0]       place;
  udss_pkg::digit_t digit;
  udss_pkg::anode_t anode_q, anode_d;
  udss_pkg::seg_t   seg_q, seg_d;

  always_comb begin
    place = 3'(DIGIT_COUNT - 1) - 3'(pos_q);
    digit = (place < 3'(udss_pkg::BCD_DIGITS)) ? digits_i[place[1:0]] : '0;
    pos_d   = pos_q;
    anode_d = anode_q;
    seg_d   = seg_q;
    if (fire_i) begin
      anode_d = (32'(pos_q) < udss_pkg::ANODE_W) ?
                udss_pkg::anode_t'(4'd1 << pos_q) : '0;
      seg_d   = udss_pkg::seg_decode(digit);
      pos_d   = (32'(pos_q) == DIGIT_COUNT - 1) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      anode_q <= '0;
      seg_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      anode_q <= anode_d;
      seg_q   <= seg_d;
    end
  end

  assign anode_o = anode_q;
  assign seg_o   = seg_q;

`ifndef NO_ASSERTIONS
  a_anode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(anode_q))
    else $error("more than one digit enabled");

  a_seg_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> seg_q != '0)
    else $error("scan latched a blank digit");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < DIGIT_COUNT)
    else $error("scan position out of range");
`endif

endmodule

@@ rtl/updown_counter_seven_segment_scan.sv @@
// ----------------------------------------------------------------------------
// updown_counter_seven_segment_scan
// Tick-driven decimal up/down counter with a multiplexed seven-segment scan.
// ----------------------------------------------------------------------------
// The block takes one tick per clock cycle and delivers its result in the
// cycle after the transfer, from the counter and display registers that the
// tick itself updates; a single register stage sets this rate, and a tick is
// taken whenever the result register is empty or being read in the same cycle.
// ----------------------------------------------------------------------------
module updown_counter_seven_segment_scan #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  udss_tick_if.sink            tick_i,
  udss_disp_if.source          disp_o
);

  udss_pkg::period_t    count_period_q, scan_period_q;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 count_fire, scan_fire;
  udss_pkg::cnt_state_t cnt_next;
  udss_pkg::count_t     count;
  udss_pkg::anode_t     anode;
  udss_pkg::seg_t       seg;

  assign tick_i.ready = !out_valid_q || disp_o.ready;
  assign accept       = tick_i.valid && tick_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_period_q <= udss_pkg::COUNT_PERIOD_RST;
      scan_period_q  <= udss_pkg::SCAN_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (udss_pkg::cfg_idx_e'(cfg_idx_i))
        udss_pkg::CFG_COUNT_PERIOD: count_period_q <= cfg_wdata_i;
        udss_pkg::CFG_SCAN_PERIOD:  scan_period_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  udss_phase u_count_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept),
    .period_i  (count_period_q),
    .fire_o    (count_fire)
  );

  udss_phase u_scan_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept),
    .period_i  (scan_period_q),
    .fire_o    (scan_fire)
  );

  udss_counter u_counter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept && count_fire),
    .up_i    (tick_i.direction_up),
    .count_o (count),
    .next_o  (cnt_next)
  );

  udss_scan #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (accept && scan_fire),
    .digits_i (cnt_next.bcd),
    .anode_o  (anode),
    .seg_o    (seg)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (disp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign disp_o.valid        = out_valid_q;
  assign disp_o.anode_select = anode;
  assign disp_o.segments     = seg;
  assign disp_o.count_value  = count;

endmodule

@@ sim/udss_scan_checker.sv @@
// ----------------------------------------------------------------------------
// udss_scan_checker
// Watches the register port and both channels of the counter/display scan
// block. It keeps its own copy of the counter, the two tick phases and the
// latched display drive, works out the drive for every tick transfer, and
// compares each result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module udss_scan_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  udss_tick_if        tick,
  udss_disp_if        disp,
  output int          err_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    udss_pkg::anode_t anode;
    udss_pkg::seg_t   seg;
    udss_pkg::count_t cnt;
  } drive_t;

  localparam udss_pkg::seg_t GLYPH [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                            7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

  udss_pkg::period_t count_period_q;
  udss_pkg::period_t scan_period_q;
  udss_pkg::period_t count_phase_q;
  udss_pkg::period_t scan_phase_q;
  udss_pkg::count_t  count_q;
  logic [1:0]        scan_pos_q;
  udss_pkg::anode_t  shown_anode_q;
  udss_pkg::seg_t    shown_seg_q;
  drive_t            drive_queue [$];
  drive_t            want;
  drive_t            got;
  int                mismatches = 0;

  function automatic udss_pkg::period_t next_phase(udss_pkg::period_t phase,
                                                   udss_pkg::period_t period);
    logic [16:0] nxt;
    nxt = phase + 17'd1;
    return (nxt >= period) ? '0 : nxt[15:0];
  endfunction

  task automatic advance_display(input logic up, output drive_t res);
    int unsigned div;
    int unsigned digit;
    if (count_phase_q == '0) begin
      if (up) begin
        count_q = (count_q >= udss_pkg::COUNT_TOP) ? '0 : count_q + 1'b1;
      end else begin
        count_q = (count_q == '0 || count_q > udss_pkg::COUNT_TOP) ?
                  udss_pkg::COUNT_TOP : count_q - 1'b1;
      end
    end
    count_phase_q = next_phase(count_phase_q, count_period_q);
    if (scan_phase_q == '0) begin
      case (scan_pos_q)
        2'd0: div = 1000;
        2'd1: div = 100;
        2'd2: div = 10;
        default: div = 1;
      endcase
      digit = (int'(count_q) / div) % 10;
      shown_anode_q = udss_pkg::anode_t'(1) << scan_pos_q;
      shown_seg_q = GLYPH[digit];
      scan_pos_q = scan_pos_q + 2'd1;
    end
    scan_phase_q = next_phase(scan_phase_q, scan_period_q);
    res.anode = shown_anode_q;
    res.seg = shown_seg_q;
    res.cnt = count_q;
  endtask

  task automatic note_mismatch(input string what, input drive_t exp_d, input drive_t act_d);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected anode %h seg %h count %0d, got anode %h seg %h count %0d",
               $realtime, what, exp_d.anode, exp_d.seg, exp_d.cnt,
               act_d.anode, act_d.seg, act_d.cnt);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_period_q = udss_pkg::COUNT_PERIOD_RST;
      scan_period_q = udss_pkg::SCAN_PERIOD_RST;
      count_phase_q = '0;
      scan_phase_q = '0;
      count_q = '0;
      scan_pos_q = '0;
      shown_anode_q = '0;
      shown_seg_q = '0;
      drive_queue.delete();
    end else begin
      if (disp.valid && disp.ready) begin
        got.anode = disp.anode_select;
        got.seg = disp.segments;
        got.cnt = disp.count_value;
        if (drive_queue.size() == 0) begin
          note_mismatch("result transfer with nothing outstanding", '0, got);
        end else begin
          want = drive_queue.pop_front();
          if (got !== want) begin
            note_mismatch("display drive mismatch", want, got);
          end
        end
      end
      if (tick.valid && tick.ready) begin
        advance_display(tick.direction_up, want);
        drive_queue.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          udss_pkg::CFG_COUNT_PERIOD: count_period_q = cfg_wdata_i;
          udss_pkg::CFG_SCAN_PERIOD:  scan_period_q = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o = drive_queue.size();
    err_count_o = mismatches;
  end

endmodule

@@ sim/updown_counter_seven_segment_scan_tb.sv @@
// ----------------------------------------------------------------------------
// updown_counter_seven_segment_scan_tb
// Drives ticks into the up/down counter with seven-segment scan and consumes
// its display results under random backpressure. A short directed sequence
// covers both wraps, zero and maximum periods and a period lowered below the
// running phase; random phases with several period settings follow. The
// checker beside the block predicts and compares every transfer.
// ----------------------------------------------------------------------------
module updown_counter_seven_segment_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  int          err_count;
  int          pending;
  bit          calm = 1'b0;
  bit          stall_req = 1'b0;
  int          stall_left = 0;

  int cp_plan [10] = '{1, 1, 2, -1, -1, 0, 1, 3, 65535, 1};
  int sp_plan [10] = '{1, 2, 1, -1, -1, 1, 0, 7, 1, 65535};

  udss_tick_if tick ();
  udss_disp_if disp ();

  updown_counter_seven_segment_scan uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .tick_i     (tick),
    .disp_o     (disp)
  );

  udss_scan_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .tick       (tick),
    .disp       (disp),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    disp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        disp.ready <= 1'b0;
        stall_left--;
      end else begin
        disp.ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic send_tick(input logic up);
    while (!calm && $urandom_range(99) < 32) begin
      tick.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick.valid <= 1'b1;
    tick.direction_up <= up;
    @(posedge clk_i);
    while (!tick.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    tick.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic program_periods(input int cp, input int sp);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= udss_pkg::CFG_COUNT_PERIOD;
    cfg_wdata_i <= 16'(cp);
    @(negedge clk_i);
    cfg_idx_i <= udss_pkg::CFG_SCAN_PERIOD;
    cfg_wdata_i <= 16'(sp);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input int n, input bit with_stall, input bit quiet);
    int   run_left;
    logic up;
    run_left = 0;
    up = 1'b0;
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      if (with_stall && i == n / 2) stall_req = 1'b1;
      if ($urandom_range(9) == 0) begin
        send_tick(1'($urandom_range(1)));
      end else begin
        if (run_left == 0) begin
          up = 1'($urandom_range(1));
          run_left = $urandom_range(1, 40);
        end
        run_left--;
        send_tick(up);
      end
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = udss_pkg::CFG_COUNT_PERIOD;
    cfg_wdata_i = '0;
    tick.valid = 1'b0;
    tick.direction_up = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset periods: the first tick steps down from zero and wraps to the top.
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // A zero period fires on every tick once the phase is back at zero; the first up step wraps back to zero.
    program_periods(0, 0);
    for (int i = 0; i < 8; i++) send_tick(i < 5);
    drain();

    // Largest periods, then periods lowered below the running phase.
    program_periods(65535, 65535);
    for (int i = 0; i < 4; i++) send_tick(1'b1);
    drain();
    program_periods(2, 3);
    for (int i = 0; i < 4; i++) send_tick(1'b0);
    drain();

    for (int p = 0; p < 10; p++) begin
      program_periods((cp_plan[p] < 0) ? $urandom_range(1, 6) : cp_plan[p],
                      (sp_plan[p] < 0) ? $urandom_range(1, 6) : sp_plan[p]);
      run_phase(155, p == 1, p == 3);
    end

    while (pending != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
